>>> rtl/rsos_pkg.sv
`timescale 1ns / 1ps

package rsos_pkg;

	// Sizes of the scan store and the object bookkeeping.
	localparam int MAX_OBJECTS = 20;
	localparam int SCAN_DEPTH  = 256;
	localparam int IDX_W       = $clog2(SCAN_DEPTH);
	localparam int COUNT_W     = 5;
	localparam int DIST_W      = 16;
	localparam int ANGLE_W     = 8;
	localparam int LIN_W       = 32;
	localparam int TAN_W       = 32;
	localparam int TAN_ENTRIES = 1 << ANGLE_W;
	localparam int FRAC_BITS   = 16;
	localparam int PROD_W      = DIST_W + 1 + TAN_W;

	// Register file layout of the configuration port.
	localparam int NUM_REGS = 2;
	localparam int ADDR_W   = $clog2(NUM_REGS * 4);
	localparam int DATA_W   = 32;

	localparam logic [DIST_W-1:0]  NEAR_THRESHOLD_RST   = 16'd100;
	localparam logic [ANGLE_W-1:0] MIN_OBJECT_WIDTH_RST = 8'd6;

	typedef enum logic {
		REG_NEAR_THRESHOLD   = 1'b0,
		REG_MIN_OBJECT_WIDTH = 1'b1
	} reg_sel_t;

	// Store access issued by the scan tracker.
	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [DIST_W-1:0] wdata;
		logic              re;
		logic [IDX_W-1:0]  raddr;
	} mem_req_t;

	// End-of-scan summary handed to the result pipeline.
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [COUNT_W-1:0] number;
		logic [IDX_W-1:0]   center;
		logic [ANGLE_W-1:0] width;
		logic               has_obj;
	} scan_sum_t;

	// Tangent table, Q16.16, built once at elaboration.
	localparam logic signed [63:0] Q31_ONE     = 64'sd2147483648;
	localparam logic signed [63:0] TAN_HI      = 64'sd2147483647;
	localparam logic signed [63:0] TAN_LO      = -64'sd2147483648;
	localparam logic signed [TAN_W-1:0] TAN_POS_SAT = 32'sh7FFF_FFFF;
	localparam logic signed [TAN_W-1:0] TAN_NEG_SAT = 32'sh8000_0001;

	typedef logic [TAN_ENTRIES-1:0][TAN_W-1:0] tan_table_t;

	// Restoring division of unsigned 64-bit values.
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] dvs);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, dvs}) begin
				rem    = rem - {1'b0, dvs};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Signed division that truncates toward zero.
	function automatic logic signed [63:0] sdiv64(input logic signed [63:0] num,
			input logic signed [63:0] dvs);
		logic [63:0] un;
		logic [63:0] ud;
		logic [63:0] uq;
		un = num[63] ? 64'(-num) : 64'(num);
		ud = dvs[63] ? 64'(-dvs) : 64'(dvs);
		uq = udiv64(un, ud);
		return (num[63] != dvs[63]) ? -$signed(uq) : $signed(uq);
	endfunction

	// Q1.31 product on magnitudes, sign applied afterwards.
	function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic [63:0]  ua;
		logic [63:0]  ub;
		logic [127:0] full;
		logic [63:0]  p;
		ua   = a[63] ? 64'(-a) : 64'(a);
		ub   = b[63] ? 64'(-b) : 64'(b);
		full = {64'd0, ua} * {64'd0, ub};
		p    = full[94:31];
		return (a[63] != b[63]) ? -$signed(p) : $signed(p);
	endfunction

	// One table entry: series on a quarter angle, then two angle doublings.
	function automatic logic signed [TAN_W-1:0] tan_entry(input logic [ANGLE_W-1:0] w);
		logic signed [63:0] x;
		logic signed [63:0] x2;
		logic signed [63:0] s;
		logic signed [63:0] c;
		logic signed [63:0] t;
		logic signed [63:0] ns;
		logic signed [63:0] nc;
		logic signed [63:0] q;
		logic [63:0]        num;
		num = 64'(w) * 64'd157 * (64'd1 << 31);
		x   = $signed(udiv64(num, 64'd36000));
		x2  = qmul(x, x);
		s   = x;
		c   = Q31_ONE;
		t   = x;
		for (int k = 1; k <= 8; k++) begin
			t = -sdiv64(qmul(t, x2), 64'(2 * k * (2 * k + 1)));
			s = s + t;
		end
		t = Q31_ONE;
		for (int k = 1; k <= 8; k++) begin
			t = -sdiv64(qmul(t, x2), 64'((2 * k - 1) * (2 * k)));
			c = c + t;
		end
		for (int r = 0; r < 2; r++) begin
			ns = qmul(s, c) <<< 1;
			nc = qmul(c, c) - qmul(s, s);
			s  = ns;
			c  = nc;
		end
		if (c == 64'sd0) begin
			return (s >= 64'sd0) ? TAN_POS_SAT : TAN_NEG_SAT;
		end
		q = sdiv64(s <<< FRAC_BITS, c);
		if (q > TAN_HI) begin
			q = TAN_HI;
		end
		if (q < TAN_LO) begin
			q = TAN_LO;
		end
		return TAN_W'(q);
	endfunction

	function automatic tan_table_t build_tan_table();
		tan_table_t tab;
		for (int i = 0; i < TAN_ENTRIES; i++) begin
			tab[i] = tan_entry(ANGLE_W'(i));
		end
		return tab;
	endfunction

	localparam tan_table_t TAN_TABLE = build_tan_table();

endpackage

>>> rtl/rsos_ram.sv
`timescale 1ns / 1ps

module rsos_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/rsos_scan.sv
`timescale 1ns / 1ps

module rsos_scan
	import rsos_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [DIST_W-1:0]  near_threshold,
	input  logic [ANGLE_W-1:0] min_object_width,
	input  logic               take,
	input  logic [DIST_W-1:0]  ir_distance,
	input  logic [DIST_W-1:0]  sonar_distance,
	input  logic               scan_last,
	output mem_req_t           mem_req,
	output logic               sum_valid,
	output scan_sum_t          sum
);

	logic               prev_near_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   start_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] best_number_q;
	logic [IDX_W-1:0]   best_center_q;
	logic [ANGLE_W-1:0] best_width_q;

	logic               near_now;
	logic               far_now;
	logic               ends;
	logic               obj_ok;
	logic               better;
	logic [IDX_W-1:0]   start_d;
	logic [IDX_W-1:0]   run_width;
	logic [ANGLE_W-1:0] width_ext;
	logic [IDX_W-1:0]   center_d;
	logic [COUNT_W-1:0] count_d;
	logic [COUNT_W-1:0] best_number_d;
	logic [IDX_W-1:0]   best_center_d;
	logic [ANGLE_W-1:0] best_width_d;

	// Classify the sample and decide whether a run closes here.
	always_comb begin
		near_now  = (ir_distance < near_threshold) && (sonar_distance < near_threshold);
		far_now   = (ir_distance > near_threshold) || (sonar_distance > near_threshold);
		start_d   = (near_now && !prev_near_q) ? idx_q : start_q;
		run_width = idx_q - start_d;
		width_ext = ANGLE_W'(run_width);
		center_d  = start_d + (run_width >> 1);
		ends      = (far_now && (idx_q != '0) && prev_near_q) || (near_now && scan_last);
		obj_ok    = ends && (start_d <= idx_q) && (width_ext > min_object_width)
			&& (count_q < COUNT_W'(MAX_OBJECTS));
		better    = (count_q == '0) || (width_ext < best_width_q);

		count_d       = count_q;
		best_number_d = best_number_q;
		best_center_d = best_center_q;
		best_width_d  = best_width_q;
		if (obj_ok) begin
			count_d = count_q + COUNT_W'(1);
			if (better) begin
				best_width_d  = width_ext;
				best_number_d = count_q + COUNT_W'(1);
				best_center_d = center_d;
			end
		end
	end

	// Scan bookkeeping; everything but the run start clears after the last sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_near_q   <= 1'b0;
			idx_q         <= '0;
			count_q       <= '0;
			best_number_q <= '0;
			best_center_q <= '0;
			best_width_q  <= '0;
		end else if (take) begin
			if (scan_last) begin
				prev_near_q   <= 1'b0;
				idx_q         <= '0;
				count_q       <= '0;
				best_number_q <= '0;
				best_center_q <= '0;
				best_width_q  <= '0;
			end else begin
				prev_near_q   <= near_now;
				if (idx_q != IDX_W'(SCAN_DEPTH - 1)) begin
					idx_q <= idx_q + IDX_W'(1);
				end
				count_q       <= count_d;
				best_number_q <= best_number_d;
				best_center_q <= best_center_d;
				best_width_q  <= best_width_d;
			end
		end
	end

	// The run start is written before any read of it within a scan.
	always_ff @(posedge clk) begin
		if (take) begin
			start_q <= start_d;
		end
	end

	// When an object was found, the center lies below the current index, so the read
	// never meets the write of the same transfer.
	always_comb begin
		mem_req.we    = take;
		mem_req.waddr = idx_q;
		mem_req.wdata = sonar_distance;
		mem_req.re    = take && scan_last;
		mem_req.raddr = best_center_d;

		sum_valid   = take && scan_last;
		sum.count   = count_d;
		sum.number  = best_number_d;
		sum.center  = best_center_d;
		sum.width   = best_width_d;
		sum.has_obj = (count_d != '0);
	end

endmodule

>>> rtl/rsos_result.sv
`timescale 1ns / 1ps

module rsos_result
	import rsos_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    sum_valid,
	input  scan_sum_t               sum,
	input  logic [DIST_W-1:0]       rdata,
	input  logic                    result_ready,
	output logic                    result_valid,
	output logic [COUNT_W-1:0]      object_count,
	output logic [COUNT_W-1:0]      narrowest_number,
	output logic [ANGLE_W-1:0]      narrowest_center,
	output logic [DIST_W-1:0]       narrowest_distance,
	output logic signed [LIN_W-1:0] narrowest_linear_width,
	output logic                    free
);

	logic                     v_s1;
	logic                     v_s2;
	logic                     v_s3;
	scan_sum_t                sum_s1;
	scan_sum_t                sum_s2;
	scan_sum_t                sum_s3;
	logic [DIST_W-1:0]        dist_s2;
	logic signed [TAN_W-1:0]  tan_s2;
	logic [DIST_W-1:0]        dist_s3;
	logic signed [PROD_W-1:0] prod_s3;

	logic                     out_valid_q;
	logic [COUNT_W-1:0]       count_q;
	logic [COUNT_W-1:0]       number_q;
	logic [ANGLE_W-1:0]       center_q;
	logic [DIST_W-1:0]        dist_q;
	logic signed [LIN_W-1:0]  lin_q;

	logic signed [DIST_W:0]   dist_sx;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] adj;
	logic signed [PROD_W-1:0] quot;

	// Stage valids; the pipeline never stalls, admission is done upstream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= sum_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Multiply the stored distance by the tangent, then divide by 2^16 toward zero.
	always_comb begin
		dist_sx = {1'b0, dist_s2};
		prod    = dist_sx * tan_s2;
		adj     = prod_s3 + (prod_s3[PROD_W-1] ? PROD_W'((1 << FRAC_BITS) - 1) : '0);
		quot    = adj >>> FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		// Stage 1: summary waits for the store read.
		sum_s1 <= sum;
		// Stage 2: store data and table lookup.
		sum_s2  <= sum_s1;
		dist_s2 <= sum_s1.has_obj ? rdata : '0;
		tan_s2  <= $signed(TAN_TABLE[sum_s1.width]);
		// Stage 3: product.
		sum_s3  <= sum_s2;
		dist_s3 <= dist_s2;
		prod_s3 <= prod;
		// Output register.
		if (v_s3) begin
			count_q  <= sum_s3.count;
			number_q <= sum_s3.number;
			center_q <= ANGLE_W'(sum_s3.center);
			dist_q   <= dist_s3;
			lin_q    <= quot[LIN_W-1:0];
		end
	end

	assign free = !v_s1 && !v_s2 && !v_s3 && (!out_valid_q || result_ready);

	assign result_valid           = out_valid_q;
	assign object_count           = count_q;
	assign narrowest_number       = number_q;
	assign narrowest_center       = center_q;
	assign narrowest_distance     = dist_q;
	assign narrowest_linear_width = lin_q;

endmodule

>>> rtl/range_scan_object_segmenter.sv
`timescale 1ns / 1ps

// Range-scan object segmenter. Each sample transfer carries one angle step of a scan; the
// sonar value is written into a 256-entry store at the sample's angle index, and runs where
// both ranges lie below near_threshold are tracked as objects. The transfer marked
// scan_last produces one result: the object count, the first narrowest object's number,
// center angle, stored sonar distance at that center, and linear width (distance times
// the Q16.16 tangent of the angular width). Non-last samples are taken one per cycle. A
// last sample is taken only once the result pipeline is empty and the result register
// is free or being read out, so a new last sample is not taken while an earlier scan's
// result is still in flight. Its result passes through the registered store read, the
// tangent lookup and the multiply, and is rounded into the output register.
// The store needs no clearing pass: every read whose data is used hits an entry written
// in the same scan. Configuration (near_threshold at 0x0, min_object_width at 0x4) is to
// be written by the user only while idle; the block itself does not enforce this.
module range_scan_object_segmenter
	import rsos_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,

	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [ADDR_W-1:0]       paddr,
	input  logic [DATA_W-1:0]       pwdata,
	output logic [DATA_W-1:0]       prdata,
	output logic                    pready,

	input  logic                    sample_valid,
	output logic                    sample_ready,
	input  logic [DIST_W-1:0]       ir_distance,
	input  logic [DIST_W-1:0]       sonar_distance,
	input  logic                    scan_last,

	output logic                    result_valid,
	input  logic                    result_ready,
	output logic [COUNT_W-1:0]      object_count,
	output logic [COUNT_W-1:0]      narrowest_number,
	output logic [ANGLE_W-1:0]      narrowest_center,
	output logic [DIST_W-1:0]       narrowest_distance,
	output logic signed [LIN_W-1:0] narrowest_linear_width
);

	logic [DIST_W-1:0]  near_threshold_q;
	logic [ANGLE_W-1:0] min_object_width_q;
	reg_sel_t           reg_sel;
	logic               cfg_wr;
	logic               take;
	logic               pipe_free;
	mem_req_t           mem_req;
	logic               sum_valid;
	scan_sum_t          sum;
	logic [DIST_W-1:0]  rdata;

	// Register file.
	assign reg_sel = reg_sel_t'(paddr[ADDR_W-1]);
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_threshold_q   <= NEAR_THRESHOLD_RST;
			min_object_width_q <= MIN_OBJECT_WIDTH_RST;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_NEAR_THRESHOLD:   near_threshold_q   <= pwdata[DIST_W-1:0];
				REG_MIN_OBJECT_WIDTH: min_object_width_q <= pwdata[ANGLE_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_NEAR_THRESHOLD:   prdata = DATA_W'(near_threshold_q);
			REG_MIN_OBJECT_WIDTH: prdata = DATA_W'(min_object_width_q);
		endcase
	end

	// A last sample waits until its result has a guaranteed slot.
	assign sample_ready = !scan_last || pipe_free;
	assign take         = sample_valid && sample_ready;

	rsos_scan u_scan (
		.clk              (clk),
		.arst_n           (arst_n),
		.near_threshold   (near_threshold_q),
		.min_object_width (min_object_width_q),
		.take             (take),
		.ir_distance      (ir_distance),
		.sonar_distance   (sonar_distance),
		.scan_last        (scan_last),
		.mem_req          (mem_req),
		.sum_valid        (sum_valid),
		.sum              (sum)
	);

	rsos_ram #(
		.WIDTH (DIST_W),
		.DEPTH (SCAN_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (rdata)
	);

	rsos_result u_result (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.sum_valid              (sum_valid),
		.sum                    (sum),
		.rdata                  (rdata),
		.result_ready           (result_ready),
		.result_valid           (result_valid),
		.object_count           (object_count),
		.narrowest_number       (narrowest_number),
		.narrowest_center       (narrowest_center),
		.narrowest_distance     (narrowest_distance),
		.narrowest_linear_width (narrowest_linear_width),
		.free                   (pipe_free)
	);

endmodule

>>> rtl/rsos_checker.sv
`timescale 1ns / 1ps

module rsos_checker
	import rsos_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    sample_valid,
	input logic                    sample_ready,
	input logic                    scan_last,
	input logic                    result_valid,
	input logic                    result_ready,
	input logic [COUNT_W-1:0]      object_count,
	input logic [COUNT_W-1:0]      narrowest_number,
	input logic [ANGLE_W-1:0]      narrowest_center,
	input logic [DIST_W-1:0]       narrowest_distance,
	input logic signed [LIN_W-1:0] narrowest_linear_width
);

	// A result that is not taken holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(object_count)
			&& $stable(narrowest_number) && $stable(narrowest_distance)
			&& $stable(narrowest_linear_width))
		else $error("stalled result changed");

	// The last sample's result shows up on time, once it has passed the pipeline stages and the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready && scan_last |-> ##4 result_valid)
		else $error("scan result did not arrive on time");

	// A last sample is only taken when the result register frees up.
	assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready && scan_last |=> !result_valid)
		else $error("last sample taken while a result was pending");

	// The narrowest object is one of the counted ones.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> narrowest_number <= object_count
			&& object_count <= COUNT_W'(MAX_OBJECTS))
		else $error("object number out of range");

	// Without objects, the narrowest fields are all zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && object_count == '0 |-> narrowest_number == '0
			&& narrowest_distance == '0 && narrowest_linear_width == '0)
		else $error("empty scan reported an object");

endmodule

bind range_scan_object_segmenter rsos_checker u_rsos_checker (.*);

>>> tb/tb_range_scan_object_segmenter.sv
`timescale 1ns / 1ps

module tb_range_scan_object_segmenter;
	import rsos_pkg::*;

	localparam int     CLK_HALF_NS     = 4;
	localparam int     RESET_CYCLES    = 6;
	localparam longint TIMEOUT_NS      = 64'd4_000_000;
	localparam int     SETTLE_CYCLES   = 10;
	localparam int     DRAIN_LIMIT     = 20000;
	localparam int     HOLD_OFF_CYCLES = 400;
	localparam int     HEAVY_IDLE_PCT  = 78;
	localparam int     LIGHT_IDLE_PCT  = 26;
	localparam int     REPORT_LIMIT    = 10;
	localparam int     SAMPLE_GOAL     = 500;
	localparam int     SCAN_GOAL       = 40;
	localparam longint Q31_UNIT        = 64'sh8000_0000;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
	typedef enum int {PICK_NEAR, PICK_FAR, PICK_EQUAL, PICK_NOISE} sample_kind_t;

	// One end-of-scan summary as it appears on the result port.
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [COUNT_W-1:0] number;
		logic [ANGLE_W-1:0] center;
		logic [DIST_W-1:0]  distance;
		logic [LIN_W-1:0]   lin_width;
	} scan_result_t;

	// Tracks objects across each scan and holds the summaries still owed by the block.
	class scan_scoreboard;
		logic [DIST_W-1:0]  near_thr;
		logic [ANGLE_W-1:0] min_width;
		bit                 prev_near;
		int unsigned        pos;
		int unsigned        run_start;
		int unsigned        found_count;
		int unsigned        best_w;
		int unsigned        best_num;
		int unsigned        best_ctr;
		logic [DIST_W-1:0]  sonar_mem [SCAN_DEPTH];
		longint             tan_q16 [TAN_ENTRIES];
		scan_result_t       owed_q [$];
		int                 mismatches;
		int                 reports;

		function new();
			near_thr   = NEAR_THRESHOLD_RST;
			min_width  = MIN_OBJECT_WIDTH_RST;
			run_start  = 0;
			mismatches = 0;
			reports    = 0;
			foreach (sonar_mem[i]) begin
				sonar_mem[i] = '0;
			end
			for (int w = 0; w < TAN_ENTRIES; w++) begin
				tan_q16[w] = tangent_q16(w);
			end
			clear_scan();
		endfunction

		function void clear_scan();
			prev_near   = 0;
			pos         = 0;
			found_count = 0;
			best_w      = 0;
			best_num    = 0;
			best_ctr    = 0;
		endfunction

		// Q1.31 product taken on magnitudes, truncated, then signed.
		function longint q31_mul(longint a, longint b);
			logic [63:0] ma;
			logic [63:0] mb;
			logic [63:0] p;
			ma = (a < 0) ? 64'(-a) : 64'(a);
			mb = (b < 0) ? 64'(-b) : 64'(b);
			p  = (ma * mb) >> 31;
			return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
		endfunction

		// Tangent of w * 3.14 / 180 in Q16.16: series on a quarter angle, two doublings.
		function longint tangent_q16(int unsigned w);
			longint unsigned num;
			longint          x;
			longint          x2;
			longint          s;
			longint          c;
			longint          term;
			longint          ns;
			longint          nc;
			longint          q;
			num  = longint'(w & 32'hFF) * 64'd157 * (64'd1 << 31);
			x    = longint'(num / 64'd36000);
			x2   = q31_mul(x, x);
			s    = x;
			term = x;
			for (int k = 1; k <= 8; k++) begin
				term = -q31_mul(term, x2) / longint'((2 * k) * (2 * k + 1));
				s += term;
			end
			c    = Q31_UNIT;
			term = Q31_UNIT;
			for (int k = 1; k <= 8; k++) begin
				term = -q31_mul(term, x2) / longint'((2 * k - 1) * (2 * k));
				c += term;
			end
			repeat (2) begin
				ns = 2 * q31_mul(s, c);
				nc = q31_mul(c, c) - q31_mul(s, s);
				s  = ns;
				c  = nc;
			end
			if (c == 0) begin
				return (s >= 0) ? 64'sd2147483647 : -64'sd2147483647;
			end
			q = (s * 65536) / c;
			if (q > 64'sd2147483647) begin
				q = 64'sd2147483647;
			end
			if (q < -64'sd2147483648) begin
				q = -64'sd2147483648;
			end
			return q;
		endfunction

		function void set_register(reg_sel_t sel, logic [DATA_W-1:0] value);
			case (sel)
				REG_NEAR_THRESHOLD: begin
					near_thr = value[DIST_W-1:0];
				end
				REG_MIN_OBJECT_WIDTH: begin
					min_width = value[ANGLE_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		// Advance the object tracker by one accepted sample; a last sample owes a summary.
		function void note_sample(logic [DIST_W-1:0] ir, logic [DIST_W-1:0] so, logic last);
			int unsigned  idx;
			int unsigned  width;
			bit           near_now;
			bit           far_now;
			bit           run_ends;
			longint       lin;
			scan_result_t res;
			idx = (pos >= SCAN_DEPTH) ? SCAN_DEPTH - 1 : pos;
			sonar_mem[idx] = so;
			near_now = (ir < near_thr) && (so < near_thr);
			far_now  = (ir > near_thr) || (so > near_thr);
			if (near_now && !prev_near) begin
				run_start = idx;
			end

			// A run closes on a far sample after a near one, or on a near last sample.
			run_ends = (far_now && idx != 0 && prev_near) || (near_now && last);
			if (run_ends && run_start <= idx) begin
				width = (idx - run_start) & 32'hFF;
				if (width > min_width && found_count < MAX_OBJECTS) begin
					if (found_count == 0 || width < best_w) begin
						best_w   = width;
						best_num = found_count + 1;
						best_ctr = (run_start + (width >> 1)) & 32'hFF;
					end
					found_count++;
				end
			end
			prev_near = near_now;

			if (!last) begin
				if (idx < SCAN_DEPTH - 1) begin
					idx++;
				end
				pos = idx;
				return;
			end

			// Build the summary of the finished scan.
			res        = '0;
			res.center = ANGLE_W'(best_ctr);
			if (found_count != 0) begin
				res.count    = COUNT_W'(found_count);
				res.number   = COUNT_W'(best_num);
				res.distance = sonar_mem[best_ctr % SCAN_DEPTH];
				lin = (longint'(res.distance) * tan_q16[best_w]) / 65536;
				res.lin_width = LIN_W'(lin);
			end
			owed_q.push_back(res);
			clear_scan();
		endfunction

		function void check_field(string name, logic [LIN_W-1:0] want, logic [LIN_W-1:0] got);
			if (got !== want) begin
				mismatches++;
				if (reports < REPORT_LIMIT) begin
					reports++;
					$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
				end
			end
		endfunction

		function void check_result(scan_result_t got);
			scan_result_t want;
			if (owed_q.size() == 0) begin
				mismatches++;
				if (reports < REPORT_LIMIT) begin
					reports++;
					$display("%0t: result transfer with no scan summary pending", $time);
				end
				return;
			end
			want = owed_q.pop_front();
			check_field("object_count", LIN_W'(want.count), LIN_W'(got.count));
			check_field("narrowest_number", LIN_W'(want.number), LIN_W'(got.number));
			check_field("narrowest_center", LIN_W'(want.center), LIN_W'(got.center));
			check_field("narrowest_distance", LIN_W'(want.distance), LIN_W'(got.distance));
			check_field("narrowest_linear_width", want.lin_width, got.lin_width);
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		function int failures();
			return mismatches + owed_q.size();
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [ADDR_W-1:0]       paddr;
	logic [DATA_W-1:0]       pwdata;
	logic [DATA_W-1:0]       prdata;
	logic                    pready;
	logic                    sample_valid;
	logic                    sample_ready;
	logic [DIST_W-1:0]       ir_distance;
	logic [DIST_W-1:0]       sonar_distance;
	logic                    scan_last;
	logic                    result_valid;
	logic                    result_ready;
	logic [COUNT_W-1:0]      object_count;
	logic [COUNT_W-1:0]      narrowest_number;
	logic [ANGLE_W-1:0]      narrowest_center;
	logic [DIST_W-1:0]       narrowest_distance;
	logic signed [LIN_W-1:0] narrowest_linear_width;

	scan_scoreboard     sb;
	idle_mode_t         idle_mode;
	logic [DIST_W-1:0]  cur_thr;
	logic [ANGLE_W-1:0] cur_minw;
	int                 hold_requests;
	int                 samples_seen;
	int                 results_seen;

	range_scan_object_segmenter i_dut (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.psel                   (psel),
		.penable                (penable),
		.pwrite                 (pwrite),
		.paddr                  (paddr),
		.pwdata                 (pwdata),
		.prdata                 (prdata),
		.pready                 (pready),
		.sample_valid           (sample_valid),
		.sample_ready           (sample_ready),
		.ir_distance            (ir_distance),
		.sonar_distance         (sonar_distance),
		.scan_last              (scan_last),
		.result_valid           (result_valid),
		.result_ready           (result_ready),
		.object_count           (object_count),
		.narrowest_number       (narrowest_number),
		.narrowest_center       (narrowest_center),
		.narrowest_distance     (narrowest_distance),
		.narrowest_linear_width (narrowest_linear_width)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#(CLK_HALF_NS) clk = ~clk;
		end
	end

	// Hard stop in case the block hangs.
	initial begin
		#(TIMEOUT_NS);
		$display("RESULT: ERROR");
		$finish;
	end

	// Sample and result transfers, observed at the clock edge.
	always @(posedge clk) begin
		if (arst_n && sample_valid && sample_ready) begin
			sb.note_sample(ir_distance, sonar_distance, scan_last);
			samples_seen++;
		end
		if (arst_n && result_valid && result_ready) begin
			sb.check_result({object_count, narrowest_number, narrowest_center,
				narrowest_distance, narrowest_linear_width});
			results_seen++;
		end
	end

	// Result receiver: random stalls, plus a long hold-off on request.
	initial begin
		int hold_count;
		int hold_served;
		hold_count  = 0;
		hold_served = 0;
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_count  = HOLD_OFF_CYCLES;
			end
			if (hold_count > 0) begin
				hold_count--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= !((idle_mode == IDLE_RECEIVER &&
					$urandom_range(0, 99) < HEAVY_IDLE_PCT) ||
					(idle_mode == IDLE_BOTH && $urandom_range(0, 99) < LIGHT_IDLE_PCT));
			end
		end
	end

	// Offer one sample, with random gaps before it, and wait for its transfer.
	task automatic send_sample(input logic [DIST_W-1:0] ir, input logic [DIST_W-1:0] so,
			input logic last);
		while ((idle_mode == IDLE_SENDER && $urandom_range(0, 99) < HEAVY_IDLE_PCT) ||
				(idle_mode == IDLE_BOTH && $urandom_range(0, 99) < LIGHT_IDLE_PCT)) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid   <= 1'b1;
		ir_distance    <= ir;
		sonar_distance <= so;
		scan_last      <= last;
		do begin
			@(posedge clk);
		end while (!sample_ready);
	endtask

	// Register write: setup phase, access phase until pready, then back to idle.
	task automatic write_reg(input reg_sel_t sel, input logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(4 * int'(sel));
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_register(sel, value);
		@(posedge clk);
	endtask

	// Stop offering samples and wait until every owed summary has arrived.
	task automatic wait_drained();
		sample_valid <= 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) begin
			@(posedge clk);
		end
	endtask

	task automatic configure(input logic [DIST_W-1:0] thr, input logic [ANGLE_W-1:0] minw);
		wait_drained();
		write_reg(REG_NEAR_THRESHOLD, DATA_W'(thr));
		write_reg(REG_MIN_OBJECT_WIDTH, DATA_W'(minw));
		cur_thr  = thr;
		cur_minw = minw;
	endtask

	// A distance below the threshold, favoring the edges.
	function automatic logic [DIST_W-1:0] below_value(logic [DIST_W-1:0] thr);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return '0;
		end else if (r == 1) begin
			return thr - 1'b1;
		end
		return DIST_W'($urandom_range(0, thr - 1));
	endfunction

	// Distances of one sample of the given kind under the current threshold.
	task automatic pick_values(input sample_kind_t kind, output logic [DIST_W-1:0] ir,
			output logic [DIST_W-1:0] so);
		logic [DIST_W-1:0] a;
		logic [DIST_W-1:0] b;
		if ((kind == PICK_NEAR && cur_thr == '0) || (kind == PICK_FAR && cur_thr == '1)) begin
			kind = PICK_EQUAL;
		end
		case (kind)
			PICK_NEAR: begin
				a = below_value(cur_thr);
				b = below_value(cur_thr);
			end
			PICK_FAR: begin
				a = ($urandom_range(0, 9) == 0) ? '1 :
					DIST_W'($urandom_range(int'(cur_thr) + 1, 65535));
				b = DIST_W'($urandom);
			end
			PICK_EQUAL: begin
				a = cur_thr;
				b = ($urandom_range(0, 3) == 0) ? cur_thr : DIST_W'($urandom_range(0, cur_thr));
			end
			default: begin
				a = DIST_W'($urandom);
				b = DIST_W'($urandom);
			end
		endcase
		if ($urandom_range(0, 1)) begin
			ir = a;
			so = b;
		end else begin
			ir = b;
			so = a;
		end
	endtask

	// One scan of alternating near runs and far gaps, with some odd samples mixed in.
	task automatic run_scan(input int len, input int near_min, input int near_max,
			input int gap_max, input int odd_pct);
		int                left;
		bit                near_mode;
		sample_kind_t      kind;
		logic [DIST_W-1:0] ir;
		logic [DIST_W-1:0] so;
		left      = 0;
		near_mode = $urandom_range(0, 1);
		for (int i = 0; i < len; i++) begin
			if (left == 0) begin
				near_mode = !near_mode;
				left = near_mode ? $urandom_range(near_min, near_max) : $urandom_range(1, gap_max);
			end
			left--;
			if ($urandom_range(0, 99) < odd_pct) begin
				kind = $urandom_range(0, 1) ? PICK_EQUAL : PICK_NOISE;
			end else begin
				kind = near_mode ? PICK_NEAR : PICK_FAR;
			end
			pick_values(kind, ir, so);
			send_sample(ir, so, i == len - 1);
		end
	endtask

	task automatic random_scans(input int scans);
		for (int n = 0; n < scans; n++) begin
			run_scan($urandom_range(1, 16), 1, int'(cur_minw) + 6, 4, 14);
		end
	endtask

	// Stimulus: directed scans, then phases with different settings and idling.
	initial begin
		int                 round;
		int                 n;
		logic [DIST_W-1:0]  thr;
		logic [ANGLE_W-1:0] minw;
		sb            = new();
		idle_mode     = IDLE_NONE;
		hold_requests = 0;
		samples_seen  = 0;
		results_seen  = 0;
		cur_thr       = NEAR_THRESHOLD_RST;
		cur_minw      = MIN_OBJECT_WIDTH_RST;
		arst_n         <= 1'b0;
		psel           <= 1'b0;
		penable        <= 1'b0;
		pwrite         <= 1'b0;
		paddr          <= '0;
		pwdata         <= '0;
		sample_valid   <= 1'b0;
		ir_distance    <= '0;
		sonar_distance <= '0;
		scan_last      <= 1'b0;
		repeat (RESET_CYCLES) begin
			@(posedge clk);
		end
		arst_n <= 1'b1;
		@(posedge clk);

		// Single-sample scans at the field extremes, near and far.
		configure(16'd100, 8'd2);
		send_sample(16'd0, 16'd0, 1'b1);
		send_sample(16'hFFFF, 16'hFFFF, 1'b1);

		// An object, a sample at the threshold, a run abandoned at the threshold,
		// a far sample that ends nothing, and a narrower object closed by a near last sample.
		send_sample(16'd10, 16'd99, 1'b0);
		send_sample(16'd99, 16'd0, 1'b0);
		send_sample(16'd0, 16'd10, 1'b0);
		send_sample(16'd99, 16'd99, 1'b0);
		send_sample(16'd101, 16'd5, 1'b0);
		send_sample(16'd100, 16'd3, 1'b0);
		send_sample(16'd3, 16'd3, 1'b0);
		send_sample(16'd4, 16'd4, 1'b0);
		send_sample(16'd5, 16'd5, 1'b0);
		send_sample(16'd100, 16'd100, 1'b0);
		send_sample(16'hFFFF, 16'd0, 1'b0);
		send_sample(16'd1, 16'd1, 1'b0);
		send_sample(16'd2, 16'd2, 1'b0);
		send_sample(16'd3, 16'd3, 1'b0);
		send_sample(16'd0, 16'd0, 1'b1);

		// Two objects of equal width: the first one stays the narrowest.
		for (n = 0; n < 10; n++) begin
			if (n == 4 || n == 9) begin
				send_sample(16'd500, 16'd7, n == 9);
			end else begin
				send_sample(16'd20 + 16'(n), 16'd40 + 16'(n), 1'b0);
			end
		end

		// Reset settings, no idling, with the receiver held off so the input backs up.
		configure(NEAR_THRESHOLD_RST, MIN_OBJECT_WIDTH_RST);
		hold_requests++;
		random_scans(8);

		// Widest settings: a scan longer than the store, near apart from a possible first sample at the threshold.
		configure(16'hFFFF, 8'd180);
		idle_mode = IDLE_SENDER;
		run_scan(260, 260, 260, 1, 0);
		random_scans(1);

		// Zero threshold: nothing can be near.
		configure(16'd0, 8'd0);
		idle_mode = IDLE_RECEIVER;
		random_scans(3);
		wait_drained();
		random_scans(3);

		// Enough one-sample objects to hit the object limit.
		configure(16'($urandom_range(1000, 60000)), 8'd0);
		idle_mode = IDLE_BOTH;
		run_scan(66, 1, 1, 1, 0);
		random_scans(4);

		// Random settings, rotating through the idling patterns.
		round = 0;
		while (samples_seen < SAMPLE_GOAL || results_seen < SCAN_GOAL) begin
			thr  = $urandom_range(0, 1) ? 16'($urandom_range(1, 65535)) :
				16'($urandom_range(20, 400));
			minw = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 180)) :
				8'($urandom_range(0, 12));
			configure(thr, minw);
			idle_mode = idle_mode_t'(round % 4);
			random_scans(6);
			round++;
		end

		// Let the last summaries come out, with a bound.
		sample_valid <= 1'b0;
		idle_mode = IDLE_NONE;
		for (n = 0; n < DRAIN_LIMIT && sb.pending() != 0; n++) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) begin
			@(posedge clk);
		end
		if (sb.failures() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
